>>> hw/rtl/uhke_pkg.sv
// Package for the Unicode hex key entry block: key codes, channel payload types
// and the hex key decode function. No dependencies.
package uhke_pkg;

  localparam int MAX_DIGITS_DEF = 6;

  localparam logic [9:0] K_ESC       = 10'd1;
  localparam logic [9:0] K_BACKSPACE = 10'd14;
  localparam logic [9:0] K_ENTER     = 10'd28;
  localparam logic [9:0] K_LCTRL     = 10'd29;
  localparam logic [9:0] K_LSHIFT    = 10'd42;
  localparam logic [9:0] K_RSHIFT    = 10'd54;
  localparam logic [9:0] K_SPACE     = 10'd57;
  localparam logic [9:0] K_KPENTER   = 10'd96;
  localparam logic [9:0] K_RCTRL     = 10'd97;
  localparam logic [9:0] K_U         = 10'd22;

  localparam logic [23:0] SURR_LO   = 24'h00D800;
  localparam logic [23:0] SURR_HI   = 24'h00DFFF;
  localparam logic [23:0] CP_MAX    = 24'h10FFFF;
  localparam logic [23:0] CP_2BYTE  = 24'h000080;
  localparam logic [23:0] CP_3BYTE  = 24'h000800;
  localparam logic [23:0] CP_4BYTE  = 24'h010000;
  localparam logic [7:0]  LEAD_2    = 8'hC0;
  localparam logic [7:0]  LEAD_3    = 8'hE0;
  localparam logic [7:0]  LEAD_4    = 8'hF0;
  localparam logic [7:0]  CONT_MARK = 8'h80;

  typedef struct packed {
    logic [9:0] key_code;
    logic       pressed;
    logic       ctrl_held;
    logic       shift_held;
    logic       alt_held;
    logic       super_held;
  } key_t;

  typedef struct packed {
    logic        consumed;
    logic        committed;
    logic [23:0] codepoint;
    logic [2:0]  utf8_length;
    logic [31:0] utf8_bytes;
    logic        collecting;
    logic [2:0]  digit_count;
    logic [23:0] digit_value;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] nib;
  } hex_t;

  // Main row 0-9, letters A-F, keypad 0-9.
  function automatic hex_t hex_of_key(logic [9:0] k);
    hex_t h;
    h.hit = 1'b1;
    h.nib = 4'd0;
    case (k)
      10'd2:  h.nib = 4'd1;
      10'd3:  h.nib = 4'd2;
      10'd4:  h.nib = 4'd3;
      10'd5:  h.nib = 4'd4;
      10'd6:  h.nib = 4'd5;
      10'd7:  h.nib = 4'd6;
      10'd8:  h.nib = 4'd7;
      10'd9:  h.nib = 4'd8;
      10'd10: h.nib = 4'd9;
      10'd11: h.nib = 4'd0;
      10'd30: h.nib = 4'd10;
      10'd48: h.nib = 4'd11;
      10'd46: h.nib = 4'd12;
      10'd32: h.nib = 4'd13;
      10'd18: h.nib = 4'd14;
      10'd33: h.nib = 4'd15;
      10'd82: h.nib = 4'd0;
      10'd79: h.nib = 4'd1;
      10'd80: h.nib = 4'd2;
      10'd81: h.nib = 4'd3;
      10'd75: h.nib = 4'd4;
      10'd76: h.nib = 4'd5;
      10'd77: h.nib = 4'd6;
      10'd71: h.nib = 4'd7;
      10'd72: h.nib = 4'd8;
      10'd73: h.nib = 4'd9;
      default: h.hit = 1'b0;
    endcase
    return h;
  endfunction

endpackage

>>> hw/rtl/uhke_stream_if.sv
// Valid/ready channel carrying one payload of type T per request.
// Uses no package; the payload type is set by the instantiating module.
interface uhke_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/uhke_utf8_enc.sv
// UTF-8 encoder: codepoint to byte count and bytes, first byte in bits 7:0.
// Depends on uhke_pkg for the range and marker constants.
module uhke_utf8_enc (
  input  logic [23:0] cp,
  output logic [2:0]  len,
  output logic [31:0] bytes
);

  logic [7:0] b0, b1, b2, b3;

  always_comb begin
    b0 = 8'h00;
    b1 = uhke_pkg::CONT_MARK | {2'b00, cp[17:12]};
    b2 = uhke_pkg::CONT_MARK | {2'b00, cp[11:6]};
    b3 = uhke_pkg::CONT_MARK | {2'b00, cp[5:0]};
    len   = 3'd0;
    bytes = 32'h0;
    if (cp < uhke_pkg::CP_2BYTE) begin
      len   = 3'd1;
      bytes = {25'h0, cp[6:0]};
    end else if (cp < uhke_pkg::CP_3BYTE) begin
      b0    = uhke_pkg::LEAD_2 | {3'b000, cp[10:6]};
      len   = 3'd2;
      bytes = {16'h0, b3, b0};
    end else if (cp < uhke_pkg::CP_4BYTE) begin
      // surrogate halves encode to nothing
      if (cp < uhke_pkg::SURR_LO || cp > uhke_pkg::SURR_HI) begin
        b0    = uhke_pkg::LEAD_3 | {4'b0000, cp[15:12]};
        len   = 3'd3;
        bytes = {8'h0, b3, b2, b0};
      end
    end else if (cp <= uhke_pkg::CP_MAX) begin
      b0    = uhke_pkg::LEAD_4 | {5'b00000, cp[20:18]};
      len   = 3'd4;
      bytes = {b3, b2, b1, b0};
    end
  end

endmodule

>>> hw/rtl/unicode_hex_key_entry.sv
// Top level of the Ctrl+Shift+U hex entry block: input register, entry
// state update, UTF-8 encode, result register. Uses uhke_pkg, uhke_stream_if, uhke_utf8_enc.
//
//   channel   dir   payload             request moves
//   keys      in    uhke_pkg::key_t     one key event
//   results   out   uhke_pkg::result_t  one result per key event
//
// A result is registered in the result register after its key request has passed the input register; one event per
// cycle is sustained while results are taken, with decode and encode combinational between the two registers.
// Reset clears both stage valids and the entry state (idle, empty buffer).
// A stalled result holds; the input register still takes a request while it is
// empty, or while the result register is empty or being drained.
module unicode_hex_key_entry #(
  parameter int MAX_DIGITS = uhke_pkg::MAX_DIGITS_DEF
) (
  input logic          clk,
  input logic          rst,
  uhke_stream_if.sink   keys,
  uhke_stream_if.source results
);

  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic              s1v;
  uhke_pkg::key_t    s1;
  logic              rv;
  uhke_pkg::result_t res;
  uhke_pkg::result_t res_next;
  logic              advance;

  logic              mode, mode_next;
  logic [23:0]       buffer, buffer_next;
  logic [CW-1:0]     cnt, cnt_next;

  logic              commit;
  logic              consumed;
  logic [23:0]       cp;
  logic [2:0]        enc_len;
  logic [31:0]       enc_bytes;
  uhke_pkg::hex_t    hx;
  logic              mod_release;

  assign advance      = !rv || results.ready;
  assign keys.ready   = !s1v || advance;
  assign results.valid = rv;
  assign results.data  = res;

  assign hx = uhke_pkg::hex_of_key(s1.key_code);
  assign mod_release = (s1.key_code == uhke_pkg::K_LSHIFT) ||
                       (s1.key_code == uhke_pkg::K_RSHIFT) ||
                       (s1.key_code == uhke_pkg::K_LCTRL)  ||
                       (s1.key_code == uhke_pkg::K_RCTRL);

  always_comb begin
    mode_next   = mode;
    buffer_next = buffer;
    cnt_next    = cnt;
    commit      = 1'b0;
    consumed    = 1'b0;
    if (mode) begin
      if (!s1.pressed) begin
        if (mod_release) begin
          commit   = 1'b1;
          consumed = 1'b1;
        end
      end else begin
        consumed = 1'b1;
        if (s1.key_code == uhke_pkg::K_ESC) begin
          mode_next   = 1'b0;
          buffer_next = 24'h0;
          cnt_next    = '0;
        end else if (s1.key_code == uhke_pkg::K_ENTER ||
                     s1.key_code == uhke_pkg::K_KPENTER ||
                     s1.key_code == uhke_pkg::K_SPACE) begin
          commit = 1'b1;
        end else if (s1.key_code == uhke_pkg::K_BACKSPACE) begin
          if (cnt != '0) begin
            cnt_next    = cnt - CW'(1);
            buffer_next = {4'h0, buffer[23:4]};
          end
        end else if (hx.hit && cnt < CW'(MAX_DIGITS)) begin
          buffer_next = {buffer[19:0], hx.nib};
          cnt_next    = cnt + CW'(1);
        end
      end
    end else if (s1.pressed && s1.ctrl_held && s1.shift_held && !s1.alt_held &&
                 !s1.super_held && s1.key_code == uhke_pkg::K_U) begin
      mode_next   = 1'b1;
      buffer_next = 24'h0;
      cnt_next    = '0;
      consumed    = 1'b1;
    end
    // commit uses the buffer as it stood, then drops back to idle
    cp = (commit && cnt != '0) ? buffer : 24'h0;
    if (commit) begin
      mode_next   = 1'b0;
      buffer_next = 24'h0;
      cnt_next    = '0;
    end
  end

  uhke_utf8_enc u_enc (
    .cp    (cp),
    .len   (enc_len),
    .bytes (enc_bytes)
  );

  always_comb begin
    res_next.consumed    = consumed;
    res_next.committed   = commit;
    res_next.codepoint   = cp;
    res_next.utf8_length = commit ? enc_len : 3'd0;
    res_next.utf8_bytes  = commit ? enc_bytes : 32'h0;
    res_next.collecting  = mode_next;
    res_next.digit_count = 3'(cnt_next);
    res_next.digit_value = buffer_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v    <= 1'b0;
      rv     <= 1'b0;
      mode   <= 1'b0;
      buffer <= 24'h0;
      cnt    <= '0;
    end else begin
      if (keys.ready) begin
        s1v <= keys.valid;
      end
      if (advance) begin
        rv <= s1v;
      end
      if (s1v && advance) begin
        mode   <= mode_next;
        buffer <= buffer_next;
        cnt    <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (keys.valid && keys.ready) begin
      s1 <= keys.data;
    end
    if (s1v && advance) begin
      res <= res_next;
    end
  end

endmodule
